### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/tos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tos_pkg
// Types and constants of the timing order statistics block.
// ----------------------------------------------------------------------------
package tos_pkg;

  localparam int TICK_W   = 32;
  localparam int HZ_W     = 27;
  localparam int COUNT_W  = 11;
  localparam int US_W     = 20;
  localparam int PROD_W   = TICK_W + US_W;
  localparam int REM_W    = HZ_W + 1;
  localparam int DCNT_W   = $clog2(PROD_W);

  localparam logic [HZ_W-1:0]  HZ_RESET  = HZ_W'(32728);
  localparam logic [US_W-1:0]  US_PER_S  = US_W'(1000000);
  localparam logic [6:0]       PCT_NUM   = 7'd95;
  localparam logic [6:0]       PCT_DEN   = 7'd100;
  localparam logic [6:0]       PCT_ROUND = 7'd99;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEL,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } tos_state_t;

  typedef enum logic [1:0] {
    SEL_MED,
    SEL_P95,
    SEL_WORST
  } tos_pick_t;

endpackage

### rtl/tos_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tos_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/timing_order_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_order_statistics
// Median, 95th percentile and worst of a set of timer samples, in ticks and
// in microseconds.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  input     | in_valid / in_ready   | sample, last
//  output    | out_valid / out_ready | mid/pct/max ticks and usec, count
//  config    | cfg_we                | cfg_wdata (timer_hz)
//
// Samples load at one beat per cycle into the sample RAM. A beat with last
// starts the summary: stored samples are read in turn as candidates, and
// each one's rank is found by sweeping the RAM, n+1 reads per candidate,
// until the median and 95th percentile are found. Then three conversions,
// each a multiply and a 52-step division, then the result loads. Reset is
// synchronous; the RAM is not cleared. in_ready is low during the summary.
// ----------------------------------------------------------------------------
module timing_order_statistics
  import tos_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [HZ_W-1:0]     cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TICK_W-1:0]   sample,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TICK_W-1:0]   mid_ticks,
  output logic [TICK_W-1:0]   pct_ticks,
  output logic [TICK_W-1:0]   max_ticks,
  output logic [TICK_W-1:0]   mid_us,
  output logic [TICK_W-1:0]   pct_us,
  output logic [TICK_W-1:0]   max_us,
  output logic [COUNT_W-1:0]  used_count,
  output logic                overflowed
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_SAMPLES);

  tos_state_t state, state_next;

  logic [HZ_W-1:0]   timer_hz;
  logic [CW-1:0]     count;
  logic [CW-1:0]     pq;
  logic [6:0]        pacc;
  logic              drop;
  logic [TICK_W-1:0] worst;

  logic [CW-1:0]     n;
  logic [CW-1:0]     med_rank;
  logic [CW-1:0]     p95_rank;
  logic [CW-1:0]     k;
  logic [CW-1:0]     k_d;
  logic [AW-1:0]     cidx;
  logic              rd_vld;
  logic [TICK_W-1:0] cand;
  logic [CW-1:0]     lt;
  logic [CW-1:0]     le;
  logic [CW-1:0]     lt_new;
  logic [CW-1:0]     le_new;
  logic              eval;
  logic              med_hit;
  logic              p95_hit;
  logic              med_found;
  logic              p95_found;
  logic [TICK_W-1:0] med_val;
  logic [TICK_W-1:0] p95_val;

  tos_pick_t         pick;
  logic [TICK_W-1:0] pick_val;
  logic [PROD_W-1:0] dvd;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  hz_eff;
  logic              q_bit;
  logic [DCNT_W-1:0] dcnt;
  logic [TICK_W-1:0] usec [3];
  logic [TICK_W-1:0] q_sat;

  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [TICK_W-1:0] ram_rdata;
  logic              in_beat;
  logic              store_ok;
  logic              publish;

  tos_ram #(
    .WIDTH (TICK_W),
    .DEPTH (MAX_SAMPLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_beat  = in_valid && in_ready;
  assign store_ok = count != CAP;

  // Rank sweep: a candidate's sorted positions are [lt, le).
  assign lt_new  = lt + CW'(ram_rdata < cand);
  assign le_new  = le + CW'(ram_rdata <= cand);
  assign eval    = (state == ST_SEL) && rd_vld && (k_d == n);
  assign med_hit = eval && (lt_new <= med_rank) && (med_rank < le_new);
  assign p95_hit = eval && (lt_new <= p95_rank) && (p95_rank < le_new);

  always_comb begin
    case (pick)
      SEL_MED: pick_val = med_val;
      SEL_P95: pick_val = p95_val;
      default: pick_val = worst;
    endcase
  end

  assign hz_eff = (timer_hz == '0) ? REM_W'(1) : REM_W'(timer_hz);
  assign rem_sh = {rem[REM_W-2:0], dvd[PROD_W-1]};
  assign q_bit  = rem_sh >= hz_eff;
  assign q_sat  = (dvd[PROD_W-2:TICK_W-1] != '0) ? '1 : {dvd[TICK_W-2:0], q_bit};
  assign publish = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_beat && last) state_next = ST_SEL;
      ST_SEL:  if ((med_found || med_hit) && (p95_found || p95_hit)) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (dcnt == DCNT_W'(PROD_W - 1)) begin
        state_next = (pick == SEL_WORST) ? ST_DONE : ST_MUL;
      end
      ST_DONE: if (publish) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = state == ST_LOAD;
    ram_we    = in_beat && store_ok;
    ram_raddr = (k == '0) ? cidx : AW'(k - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      timer_hz  <= HZ_RESET;
      count     <= '0;
      pq        <= '0;
      pacc      <= PCT_ROUND;
      drop      <= 1'b0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= state == ST_SEL;
      if (cfg_we) begin
        timer_hz <= cfg_wdata;
      end
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_beat) begin
        if (store_ok) begin
          count <= count + CW'(1);
          // Running ceil(count*95/100): adding 95 carries past 100 unless
          // the remainder is below 5.
          if (pacc >= PCT_DEN - PCT_NUM) begin
            pq   <= pq + CW'(1);
            pacc <= pacc - (PCT_DEN - PCT_NUM);
          end else begin
            pacc <= pacc + PCT_NUM;
          end
        end else begin
          drop <= 1'b1;
        end
      end
      if (publish) begin
        count <= '0;
        pq    <= '0;
        pacc  <= PCT_ROUND;
        drop  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && store_ok) begin
      worst <= (count == '0 || sample > worst) ? sample : worst;
    end
    k_d <= k;
    unique case (state)
      ST_LOAD: begin
        k         <= '0;
        cidx      <= '0;
        med_found <= 1'b0;
        p95_found <= 1'b0;
        pick      <= SEL_MED;
        n         <= count + CW'(store_ok);
        med_rank  <= (count + CW'(store_ok)) >> 1;
        if (store_ok && pacc >= PCT_DEN - PCT_NUM) begin
          p95_rank <= pq;
        end else begin
          p95_rank <= pq - CW'(1);
        end
      end
      ST_SEL: begin
        if (k == n) begin
          k    <= '0;
          cidx <= cidx + AW'(1);
        end else begin
          k <= k + CW'(1);
        end
        if (rd_vld) begin
          if (k_d == '0) begin
            cand <= ram_rdata;
            lt   <= '0;
            le   <= '0;
          end else begin
            lt <= lt_new;
            le <= le_new;
          end
        end
        if (med_hit && !med_found) begin
          med_found <= 1'b1;
          med_val   <= cand;
        end
        if (p95_hit && !p95_found) begin
          p95_found <= 1'b1;
          p95_val   <= cand;
        end
      end
      ST_MUL: begin
        dvd  <= PROD_W'(pick_val) * PROD_W'(US_PER_S);
        rem  <= '0;
        dcnt <= '0;
      end
      ST_DIV: begin
        rem  <= q_bit ? rem_sh - hz_eff : rem_sh;
        dvd  <= {dvd[PROD_W-2:0], q_bit};
        dcnt <= dcnt + DCNT_W'(1);
        if (dcnt == DCNT_W'(PROD_W - 1)) begin
          usec[pick] <= q_sat;
          pick       <= tos_pick_t'(pick + 2'd1);
        end
      end
      default: begin
        if (publish) begin
          mid_ticks  <= med_val;
          pct_ticks  <= p95_val;
          max_ticks  <= worst;
          mid_us     <= usec[SEL_MED];
          pct_us     <= usec[SEL_P95];
          max_us     <= usec[SEL_WORST];
          used_count <= COUNT_W'(n);
          overflowed <= drop;
        end
      end
    endcase
  end

endmodule

### rtl/tos_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tos_checker
// Port-level checks of the order statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tos_checker
  import tos_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TICK_W-1:0]  mid_ticks,
  input logic [TICK_W-1:0]  pct_ticks,
  input logic [TICK_W-1:0]  max_ticks,
  input logic [TICK_W-1:0]  mid_us,
  input logic [TICK_W-1:0]  pct_us,
  input logic [TICK_W-1:0]  max_us,
  input logic [COUNT_W-1:0] used_count
);

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result beat dropped")
  `ASSERT_CLK(a_tick_order, clk, rst, out_valid |-> mid_ticks <= pct_ticks && pct_ticks <= max_ticks, "ticks out of order")
  `ASSERT_CLK(a_usec_order, clk, rst, out_valid |-> mid_us <= pct_us && pct_us <= max_us, "usec out of order")
  `ASSERT_CLK(a_count_nz, clk, rst, out_valid |-> used_count != '0, "summary with no samples")

endmodule

bind timing_order_statistics tos_checker u_tos_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .mid_ticks  (mid_ticks),
  .pct_ticks  (pct_ticks),
  .max_ticks  (max_ticks),
  .mid_us     (mid_us),
  .pct_us     (pct_us),
  .max_us     (max_us),
  .used_count (used_count)
);
